// ----- src/cdeq_pkg.sv -----
// Shared types and constants for the cell division event queue.
`timescale 1ns / 1ps
`default_nettype none
package cdeq_pkg;

    localparam int TIME_W   = 32;
    localparam int POP_W    = 11;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 8;

    // Input item kinds (carried on tuser)
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_DIVIDE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CAP      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_RATE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POPULATION = 8'd1;

    localparam logic [TIME_W-1:0] INVERSE_RATE_RESET   = 32'h0001_0000;
    localparam logic [POP_W-1:0]  MAX_POPULATION_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_POP,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [TIME_W-1:0] value;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHILD1,
        S_INS1,
        S_INS2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POP_W-1:0]    population;
        logic [TIME_W-1:0]   popped_time;
    } result_t;

endpackage
`default_nettype wire

// ----- src/cdeq_cell.sv -----
// One cell of the sorted queue: holds one time, shifts left on pop, opens a slot on insert.
`timescale 1ns / 1ps
`default_nettype none
module cdeq_cell (
    input  logic                      clk,
    input  cdeq_pkg::cell_cmd_t       cmd,
    input  logic                      occupied,
    input  logic [cdeq_pkg::TIME_W-1:0] left_value,
    input  logic                      left_keep,
    input  logic [cdeq_pkg::TIME_W-1:0] right_value,
    output logic [cdeq_pkg::TIME_W-1:0] value,
    output logic                      keep
);
    import cdeq_pkg::*;

    logic [TIME_W-1:0] value_reg;
    logic [TIME_W-1:0] value_next;

    // keep: this cell holds a time not above the one being inserted
    assign keep  = occupied && (value_reg <= cmd.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.op)
            OP_POP:
            begin
                value_next = right_value;
            end
            OP_INSERT:
            begin
                if (!keep)
                begin
                    value_next = left_keep ? cmd.value : left_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule
`default_nettype wire

// ----- src/cdeq_chain.sv -----
// Row of queue cells kept in ascending order; cell 0 holds the earliest time.
`timescale 1ns / 1ps
`default_nettype none
module cdeq_chain #(
    parameter int CAPACITY = 1024
) (
    input  logic                              clk,
    input  cdeq_pkg::cell_cmd_t               cmd,
    input  logic [$clog2(CAPACITY+1)-1:0]     count,
    output logic [cdeq_pkg::TIME_W-1:0]       head
);
    import cdeq_pkg::*;

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic [TIME_W-1:0] vals  [CAPACITY];
    logic              keeps [CAPACITY];
    logic              occ   [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [TIME_W-1:0] lv;
            logic              lk;
            logic [TIME_W-1:0] rv;

            assign occ[i] = (COUNT_W'(i) < count);

            if (i == 0)
            begin : g_first
                assign lv = vals[i];
                assign lk = 1'b1;
            end
            else
            begin : g_mid
                assign lv = vals[i-1];
                assign lk = keeps[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign rv = vals[i];
            end
            else
            begin : g_inner
                assign rv = vals[i+1];
            end

            cdeq_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (occ[i]),
                .left_value  (lv),
                .left_keep   (lk),
                .right_value (rv),
                .value       (vals[i]),
                .keep        (keeps[i])
            );
        end
    endgenerate

    assign head = vals[0];

endmodule
`default_nettype wire

// ----- src/cell_division_event_queue_core.sv -----
// Top level of the cell division event queue: control, child time math, stream ports.
//
// Next-event scheduler for cell division. The queue is a row of CAPACITY cells
// kept sorted, earliest time in cell 0; a pop shifts the row left and an insert
// opens a slot at the right place.
// Input channel (s_axis): tuser is the kind (0 load, 1 divide); tdata carries
// start_time, first_draw and second_draw. Output channel (m_axis): one result
// transaction per input transaction with popped_time, population and status.
// Config channel (cfg_*): always ready; index 0 inverse_rate, 1 max_population,
// other indexes are dropped. Write only while no item is in flight.
// Timing: a load or a refused divide posts its result at the edge that accepts
// it; an accepted divide runs in steps (pop and first product, second product,
// insert child one, insert child two). Throughput: one load per cycle while the
// output is not stalled; a divide keeps the input closed until it finishes, as
// its steps share the 32x32 multiplier and the single insert per cycle on the row.
// Reset empties the queue (count to zero), loads the register reset values and
// drops any pending output. When the receiver stalls, the output register holds
// its transaction; one more finished result parks in a holding register and the
// input channel stays closed until it moves out.
`timescale 1ns / 1ps
`default_nettype none
module cell_division_event_queue_core #(
    parameter int CAPACITY      = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [95:0]                      s_axis_tdata,  // start_time, first_draw, second_draw
    input  logic                             s_axis_tuser,  // kind
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [47:0]                      m_axis_tdata,  // popped_time, population, status, zero pad
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cdeq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cdeq_pkg::TIME_W-1:0]      cfg_data
);
    import cdeq_pkg::*;

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (COUNT_W > POP_W) ? COUNT_W : POP_W;
    localparam int PROD_W  = 2 * TIME_W;
    localparam int RES_W   = TIME_W + POP_W + STATUS_W;

    // input fields
    logic [TIME_W-1:0] in_start;
    logic [TIME_W-1:0] in_draw1;
    logic [TIME_W-1:0] in_draw2;
    assign in_start = s_axis_tdata[TIME_W-1:0];
    assign in_draw1 = s_axis_tdata[2*TIME_W-1:TIME_W];
    assign in_draw2 = s_axis_tdata[3*TIME_W-1:2*TIME_W];

    // registers
    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0]   inv_rate_reg;
    logic [POP_W-1:0]    max_pop_reg;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [TIME_W-1:0]   popped_reg, popped_next;
    logic [TIME_W-1:0]   draw2_reg, draw2_next;
    logic [TIME_W-1:0]   child_reg, child_next;
    result_t             pend_reg, pend_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    cell_cmd_t           cmd;
    logic [TIME_W-1:0]   head;

    cdeq_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .clk   (clk),
        .cmd   (cmd),
        .count (count_reg),
        .head  (head)
    );

    // child time = popped + (draw * inverse_rate) >> FRACTION_BITS, saturated
    logic [TIME_W:0]   child_sum;
    logic              delta_ovf;
    logic [TIME_W-1:0] child_time;
    always_comb
    begin
        delta_ovf  = |prod_reg[PROD_W-1:TIME_W+FRACTION_BITS];
        child_sum  = {1'b0, popped_reg}
                   + {1'b0, prod_reg[TIME_W+FRACTION_BITS-1:FRACTION_BITS]};
        child_time = (delta_ovf || child_sum[TIME_W]) ? {TIME_W{1'b1}}
                                                      : child_sum[TIME_W-1:0];
    end

    // one 32x32 multiplier: first draw while idle, second draw after that
    logic [TIME_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_prod;
    assign mul_a    = (state_reg == S_IDLE) ? in_draw1 : draw2_reg;
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(inv_rate_reg);

    // count checks and population field
    logic [CMP_W-1:0]           count_cmp;
    logic                       cap_hit;
    logic                       is_empty;
    logic                       is_full;
    logic [COUNT_W-1:0]         count_inc;
    logic [COUNT_W+POP_W-1:0]   count_inc_wide;
    logic [POP_W-1:0]           pop_after_inc;
    always_comb
    begin
        count_cmp      = CMP_W'(count_reg);
        cap_hit        = (count_cmp >= CMP_W'(max_pop_reg));
        is_empty       = (count_reg == '0);
        is_full        = (count_reg == COUNT_W'(CAPACITY));
        count_inc      = count_reg + COUNT_W'(1);
        count_inc_wide = {{POP_W{1'b0}}, count_inc};
        pop_after_inc  = count_inc_wide[POP_W-1:0];
    end

    logic [COUNT_W+POP_W-1:0] count_wide;
    logic [POP_W-1:0]         pop_now;
    assign count_wide = {{POP_W{1'b0}}, count_reg};
    assign pop_now    = count_wide[POP_W-1:0];

    logic out_free;
    logic in_fire;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // control
    logic    fin_valid;
    result_t fin;
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        prod_next   = prod_reg;
        popped_next = popped_reg;
        draw2_next  = draw2_reg;
        child_next  = child_reg;
        cmd.op      = OP_HOLD;
        cmd.value   = child_reg;
        fin_valid   = 1'b0;
        fin         = pend_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    fin_valid       = 1'b1;
                    fin.popped_time = '0;
                    fin.population  = pop_now;
                    if (s_axis_tuser == KIND_LOAD)
                    begin
                        if (is_full)
                        begin
                            fin.status = STATUS_FULL;
                        end
                        else
                        begin
                            cmd.op         = OP_INSERT;
                            cmd.value      = in_start;
                            count_next     = count_inc;
                            fin.population = pop_after_inc;
                            fin.status     = STATUS_DONE;
                        end
                    end
                    else
                    begin
                        priority if (cap_hit)
                        begin
                            fin.status = STATUS_CAP;
                        end
                        else if (is_empty)
                        begin
                            fin.status = STATUS_EMPTY;
                        end
                        else if (is_full)
                        begin
                            fin.status = STATUS_FULL;
                        end
                        else
                        begin
                            fin_valid   = 1'b0;
                            cmd.op      = OP_POP;
                            count_next  = count_reg - COUNT_W'(1);
                            popped_next = head;
                            prod_next   = mul_prod;
                            draw2_next  = in_draw2;
                            state_next  = S_CHILD1;
                        end
                    end
                end
            end
            S_CHILD1:
            begin
                child_next = child_time;
                prod_next  = mul_prod;
                state_next = S_INS1;
            end
            S_INS1:
            begin
                cmd.op     = OP_INSERT;
                cmd.value  = child_reg;
                count_next = count_inc;
                child_next = child_time;
                state_next = S_INS2;
            end
            S_INS2:
            begin
                cmd.op          = OP_INSERT;
                cmd.value       = child_reg;
                count_next      = count_inc;
                fin_valid       = 1'b1;
                fin.popped_time = popped_reg;
                fin.population  = pop_after_inc;
                fin.status      = STATUS_DONE;
            end
            S_DONE:
            begin
                fin_valid = 1'b1;
                fin       = pend_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the finished result to the output register, or park it
        if (fin_valid)
        begin
            state_next = out_free ? S_IDLE : S_DONE;
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (fin_valid)
        begin
            if (out_free)
            begin
                out_next       = fin;
                out_valid_next = 1'b1;
            end
            else
            begin
                pend_next = fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_rate_reg <= INVERSE_RATE_RESET;
            max_pop_reg  <= MAX_POPULATION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_INVERSE_RATE)
            begin
                inv_rate_reg <= cfg_data;
            end
            else if (cfg_index == REG_MAX_POPULATION)
            begin
                max_pop_reg <= cfg_data[POP_W-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        popped_reg <= popped_next;
        draw2_reg  <= draw2_next;
        child_reg  <= child_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(48 - RES_W){1'b0}}, out_reg.status, out_reg.population,
                            out_reg.popped_time};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("queue count above capacity");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_INSERT |-> count_reg < COUNT_W'(CAPACITY))
        else $error("insert into a full cell row");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_POP |-> count_reg != '0)
        else $error("pop from an empty cell row");

    a_park_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> out_valid_reg)
        else $error("result parked while output register empty");

    a_divide_grows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS2 |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("divide did not leave one more cell");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_cell_division_event_queue_core.sv -----
// Self-checking testbench for the cell division event queue core.
`timescale 1ns / 1ps
module tb_cell_division_event_queue_core;
    import cdeq_pkg::*;

    localparam int CAPACITY      = 1024;
    localparam int FRACTION_BITS = 16;
    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int MAX_IDLE      = 19;
    // settle time after the last result, long enough for a divide in flight to finish
    localparam int DRAIN_CYCLES  = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTED  = 10;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 240;
    localparam int PRESSURE_ITEMS = 30;
    localparam int NOISE_W       = TIME_W - POP_W;

    // register indexes outside the map; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

    localparam logic [TIME_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [95:0]          s_axis_tdata  = '0;  // start_time, first_draw, second_draw
    logic                 s_axis_tuser  = 1'b0; // kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;  // popped_time, population, status, zero pad
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data  = '0;

    // predictor state: queued division times (order irrelevant, min is popped)
    logic [TIME_W-1:0] queued_times[$];
    logic [TIME_W-1:0] model_inverse_rate   = INVERSE_RATE_RESET;
    logic [POP_W-1:0]  model_max_population = MAX_POPULATION_RESET;

    // one entry per accepted input transaction, oldest first
    result_t pending_results[$];

    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned error_count     = 0;
    int unsigned peak_population = 0;
    int unsigned holds_done      = 0;
    int unsigned cycle_count     = 0;

    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    bit hold_request    = 1'b0;

    cell_division_event_queue_core #(
        .CAPACITY      (CAPACITY),
        .FRACTION_BITS (FRACTION_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // parent time plus scaled draw, saturating at the top of the range
    function automatic logic [TIME_W-1:0] child_time(logic [TIME_W-1:0] parent,
                                                     logic [TIME_W-1:0] draw);
        logic [63:0] delta;
        logic [63:0] sum;
        delta = ({32'd0, draw} * {32'd0, model_inverse_rate}) >> FRACTION_BITS;
        sum   = {32'd0, parent} + delta;
        return (sum > 64'h0000_0000_FFFF_FFFF) ? ALL_ONES : sum[TIME_W-1:0];
    endfunction

    function automatic result_t predict_division_result(logic kind,
                                                        logic [TIME_W-1:0] start_time,
                                                        logic [TIME_W-1:0] first_draw,
                                                        logic [TIME_W-1:0] second_draw);
        result_t     res;
        int unsigned count;
        int          min_idx;
        logic [TIME_W-1:0] popped;
        count  = queued_times.size();
        popped = '0;
        res.status = STATUS_DONE;
        if (kind == KIND_LOAD) begin
            if (count >= CAPACITY)
                res.status = STATUS_FULL;
            else
                queued_times.push_back(start_time);
        end else begin
            // refusal order: cap, empty, no room for the extra child
            if (count >= model_max_population)
                res.status = STATUS_CAP;
            else if (count == 0)
                res.status = STATUS_EMPTY;
            else if (count >= CAPACITY)
                res.status = STATUS_FULL;
            else begin
                min_idx = 0;
                foreach (queued_times[i])
                    if (queued_times[i] < queued_times[min_idx])
                        min_idx = i;
                popped = queued_times[min_idx];
                queued_times.delete(min_idx);
                queued_times.push_back(child_time(popped, first_draw));
                queued_times.push_back(child_time(popped, second_draw));
            end
        end
        if (queued_times.size() > peak_population)
            peak_population = queued_times.size();
        res.popped_time = popped;
        res.population  = POP_W'(queued_times.size());
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Called at a falling edge, returns at the falling edge after the transaction.
    // tvalid is left high so a back-to-back item never toggles it in one step.
    task automatic send_item(logic kind, logic [TIME_W-1:0] start_time,
                             logic [TIME_W-1:0] first_draw,
                             logic [TIME_W-1:0] second_draw);
        int unsigned gap;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {second_draw, first_draw, start_time};
        do @(posedge clk); while (!s_axis_tready);
        pending_results.push_back(
            predict_division_result(kind, start_time, first_draw, second_draw));
        items_sent++;
        @(negedge clk);
    endtask

    // Called at a falling edge; closes the input and waits for the block to go idle.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_INVERSE_RATE)
            model_inverse_rate = data;
        else if (idx == REG_MAX_POPULATION)
            model_max_population = data[POP_W-1:0];
    endtask

    // Both registers, written once the block is idle. Upper bits of the
    // population word carry noise that the block must drop.
    task automatic apply_config(logic [TIME_W-1:0] rate, logic [POP_W-1:0] max_pop);
        logic [NOISE_W-1:0] noise;
        noise = NOISE_W'($urandom_range(0, (1 << NOISE_W) - 1));
        wait_for_results();
        cfg_write(REG_INVERSE_RATE, rate);
        cfg_write(REG_MAX_POPULATION, {noise, max_pop});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // exponential-like small draws most of the time, plus wide values and extremes
    function automatic logic [TIME_W-1:0] random_draw();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom_range(0, 32'h0003_0000);
            2:       return $urandom;
            default: return $urandom_range(0, 1) ? ALL_ONES : '0;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] random_rate();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'd1;
            2:       return INVERSE_RATE_RESET;
            3:       return ALL_ONES;
            4:       return $urandom;
            default: return $urandom_range(32'h0000_0100, 32'h0004_0000);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        @(negedge clk);
        forever
        begin
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
                holds_done++;
            end else begin
                stall = receiver_steady ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every output transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTED)
                    $display("ERROR: result with nothing pending: popped=%h pop=%0d status=%0d",
                             got.popped_time, got.population, got.status);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.popped_time != want.popped_time || got.population != want.population
                    || got.status != want.status) begin
                    error_count++;
                    if (error_count <= MAX_REPORTED)
                        $display({"ERROR: result %0d: popped=%h exp %h, pop=%0d exp %0d, ",
                                  "status=%0d exp %0d"}, results_checked,
                                 got.popped_time, want.popped_time,
                                 got.population, want.population,
                                 got.status, want.status);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_cell_division_event_queue_core: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // empty queue refusal, cap taking priority over empty, dropped register writes
    task automatic test_refusals_on_empty();
        send_item(KIND_DIVIDE, ALL_ONES, ALL_ONES, ALL_ONES);
        apply_config(INVERSE_RATE_RESET, '0);
        send_item(KIND_DIVIDE, '0, '0, '0);
        wait_for_results();
        cfg_write(REG_UNUSED_LO, '0);
        cfg_write(REG_UNUSED_HI, ALL_ONES);
        @(negedge clk);
        cfg_valid <= 1'b0;
        // max population still zero: still refused
        send_item(KIND_DIVIDE, $urandom, $urandom, $urandom);
        apply_config(INVERSE_RATE_RESET, MAX_POPULATION_RESET);
    endtask

    // extreme start times, equal times; loads report popped time zero
    task automatic test_load_extremes();
        send_item(KIND_LOAD, ALL_ONES, '0, '0);
        send_item(KIND_LOAD, '0, ALL_ONES, ALL_ONES);
        send_item(KIND_LOAD, 32'h8000_0000, $urandom, $urandom);
        send_item(KIND_LOAD, 32'd5, $urandom, $urandom);
        send_item(KIND_LOAD, 32'd5, $urandom, $urandom);
        send_item(KIND_LOAD, 32'h0001_0000, $urandom, $urandom);
    endtask

    // child time arithmetic at the rate extremes and saturation
    task automatic test_child_time_math();
        send_item(KIND_DIVIDE, $urandom, '0, '0);
        send_item(KIND_DIVIDE, $urandom, ALL_ONES, ALL_ONES);
        apply_config(ALL_ONES, MAX_POPULATION_RESET);
        send_item(KIND_DIVIDE, ALL_ONES, ALL_ONES, 32'h0001_0000);
        apply_config('0, MAX_POPULATION_RESET);
        send_item(KIND_DIVIDE, $urandom, $urandom, $urandom);
        // cap equal to the population: divides refused, loads still go in
        apply_config(32'h0000_8000, POP_W'(queued_times.size()));
        send_item(KIND_DIVIDE, $urandom, $urandom, $urandom);
        send_item(KIND_LOAD, 32'h0000_0003, $urandom, $urandom);
        send_item(KIND_DIVIDE, $urandom, $urandom, $urandom);
    endtask

    task automatic send_random_item();
        logic kind;
        logic [TIME_W-1:0] start_time;
        kind = ($urandom_range(0, 99) < 80) ? KIND_DIVIDE : KIND_LOAD;
        if (kind == KIND_LOAD) begin
            start_time = $urandom_range(0, 1) ? $urandom_range(0, 32'h00FF_FFFF) : $urandom;
            send_item(kind, start_time, $urandom, $urandom);
        end else begin
            send_item(kind, $urandom, random_draw(), random_draw());
        end
    endtask

    // the receiver holds off long enough that the block fills and closes its input
    task automatic test_output_backpressure();
        apply_config(random_rate(), MAX_POPULATION_RESET);
        hold_request  = 1'b1;
        sender_steady = 1'b1;
        repeat (PRESSURE_ITEMS) send_random_item();
        sender_steady = 1'b0;
    endtask

    // mixed traffic over several register settings and idling patterns
    task automatic test_random_traffic();
        int unsigned target;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 4)
                target = $urandom_range(0, (1 << POP_W) - 1);
            else begin
                target = queued_times.size() + $urandom_range(40, 160);
                if (target > 1000)
                    target = (queued_times.size() > 1000) ? queued_times.size() : 1000;
            end
            apply_config((phase == 0) ? INVERSE_RATE_RESET : random_rate(), POP_W'(target));
            sender_steady   = (phase == 2) || (phase == 5);
            receiver_steady = (phase == 3) || (phase == 5);
            repeat (PHASE_ITEMS) send_random_item();
            if (phase == 3)
                test_output_backpressure();
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // full queue: load refused, divide refused by cap first, then by room
    task automatic test_fill_to_capacity();
        logic [TIME_W-1:0] rate;
        rate = random_rate();
        apply_config(rate, MAX_POPULATION_RESET);
        while (queued_times.size() < CAPACITY)
            send_item(KIND_LOAD, $urandom, $urandom, $urandom);
        send_item(KIND_LOAD, $urandom, $urandom, $urandom);
        send_item(KIND_DIVIDE, $urandom, random_draw(), random_draw());
        apply_config(rate, {POP_W{1'b1}});
        send_item(KIND_DIVIDE, $urandom, random_draw(), random_draw());
        send_item(KIND_LOAD, $urandom, $urandom, $urandom);
        apply_config(rate, '0);
        send_item(KIND_DIVIDE, $urandom, random_draw(), random_draw());
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_refusals_on_empty();
        test_load_extremes();
        test_child_time_math();
        test_random_traffic();
        test_fill_to_capacity();
        wait_for_results();

        $display("Covered %0d input transactions and %0d checked results in %0d cycles.",
                 items_sent, results_checked, cycle_count);
        $display("Peak population %0d of %0d, %0d long output hold-off(s).",
                 peak_population, CAPACITY, holds_done);
        if (error_count == 0)
            $display("tb_cell_division_event_queue_core: done, clean");
        else
            $display("tb_cell_division_event_queue_core: done, errors");
        $finish;
    end

endmodule
